[hdl/hkmc_pkg.sv]
// Shared types, constants and helper functions for the haptic knob mode controller.
package hkmc_pkg;

   // Fixed-point format of angles, velocities and targets
   localparam int FIXED_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // Field widths
   localparam int MODE_WIDTH  = 3;
   localparam int STEP_WIDTH  = 19;
   localparam int BAND_WIDTH  = 31;
   localparam int DRIVE_WIDTH = 2;
   localparam int CAP_WIDTH   = 10;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KNOB_MODE        = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DETENT_STEP      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LIMIT_LOW        = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LIMIT_HIGH       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INERTIA_DEADBAND = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INERTIA_JUMP     = 3'd5;

   // Knob mode codes (code 7 is unused and acts as the off mode)
   localparam logic [MODE_WIDTH-1:0] MODE_OFF      = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_FLYWHEEL = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_DETENT   = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_RETURN   = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_BOUNDED  = 3'd4;
   localparam logic [MODE_WIDTH-1:0] MODE_ROTATE   = 3'd5;
   localparam logic [MODE_WIDTH-1:0] MODE_HOST     = 3'd6;

   // Motor loop drive mode codes
   localparam logic [DRIVE_WIDTH-1:0] DRIVE_TORQUE   = 2'd0;
   localparam logic [DRIVE_WIDTH-1:0] DRIVE_VELOCITY = 2'd1;
   localparam logic [DRIVE_WIDTH-1:0] DRIVE_ANGLE    = 2'd2;

   // Torque caps in Q2.8
   localparam logic [CAP_WIDTH-1:0] CAP_NONE    = 10'd0;
   localparam logic [CAP_WIDTH-1:0] CAP_INERTIA = 10'd128;  // 0.5
   localparam logic [CAP_WIDTH-1:0] CAP_ENCODER = 10'd154;  // 0.6
   localparam logic [CAP_WIDTH-1:0] CAP_STRONG  = 10'd384;  // 1.5
   localparam logic [CAP_WIDTH-1:0] CAP_PROGRAM = 10'd256;  // 1.0

   // Rotate mode entry velocity: 10.0 in fixed point
   localparam logic signed [FIXED_WIDTH-1:0] SPIN_TARGET =
      FIXED_WIDTH'(64'd10 << FRAC_BITS);

   // Configuration register set
   typedef struct packed {
      logic [MODE_WIDTH-1:0]         knob_mode;
      logic [STEP_WIDTH-1:0]         detent_step;
      logic signed [FIXED_WIDTH-1:0] limit_low;
      logic signed [FIXED_WIDTH-1:0] limit_high;
      logic [BAND_WIDTH-1:0]         inertia_deadband;
      logic [BAND_WIDTH-1:0]         inertia_jump;
   } cfg_type;

   // Request payload
   typedef struct packed {
      logic                          restart;
      logic signed [FIXED_WIDTH-1:0] angle;
      logic signed [FIXED_WIDTH-1:0] velocity;
   } req_type;

   // Response payload
   typedef struct packed {
      logic                          motor_enable;
      logic [DRIVE_WIDTH-1:0]        drive_mode;
      logic signed [FIXED_WIDTH-1:0] motor_target;
      logic [CAP_WIDTH-1:0]          torque_cap;
      logic signed [FIXED_WIDTH-1:0] detent_count;
   } rsp_type;

   // Motor is driven in every defined mode but the off mode
   function automatic logic mode_enables(input logic [MODE_WIDTH-1:0] mode);
      logic en;
      case (mode)
         MODE_FLYWHEEL, MODE_DETENT, MODE_RETURN, MODE_BOUNDED, MODE_ROTATE,
         MODE_HOST: en = 1'b1;
         default:   en = 1'b0;
      endcase
      return en;
   endfunction

   // Torque limit per mode
   function automatic logic [CAP_WIDTH-1:0] cap_for(input logic [MODE_WIDTH-1:0] mode);
      logic [CAP_WIDTH-1:0] cap;
      case (mode)
         MODE_FLYWHEEL:                         cap = CAP_INERTIA;
         MODE_DETENT:                           cap = CAP_ENCODER;
         MODE_RETURN, MODE_BOUNDED, MODE_ROTATE: cap = CAP_STRONG;
         MODE_HOST:                             cap = CAP_PROGRAM;
         default:                               cap = CAP_NONE;
      endcase
      return cap;
   endfunction

endpackage

[hdl/hkmc_csr.sv]
// Configuration register file of the haptic knob mode controller.
module hkmc_csr
   import hkmc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_KNOB_MODE:        cfg_in.knob_mode        = csr_wdata[MODE_WIDTH-1:0];
            REG_DETENT_STEP:      cfg_in.detent_step      = csr_wdata[STEP_WIDTH-1:0];
            REG_LIMIT_LOW:        cfg_in.limit_low        = $signed(csr_wdata[FIXED_WIDTH-1:0]);
            REG_LIMIT_HIGH:       cfg_in.limit_high       = $signed(csr_wdata[FIXED_WIDTH-1:0]);
            REG_INERTIA_DEADBAND: cfg_in.inertia_deadband = csr_wdata[BAND_WIDTH-1:0];
            REG_INERTIA_JUMP:     cfg_in.inertia_jump     = csr_wdata[BAND_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.knob_mode        <= MODE_OFF;
         cfg_ff.detent_step      <= STEP_WIDTH'(17157);
         cfg_ff.limit_low        <= '0;
         cfg_ff.limit_high       <= '0;
         cfg_ff.inertia_deadband <= BAND_WIDTH'(65536);
         cfg_ff.inertia_jump     <= BAND_WIDTH'(19661);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/hkmc_core.sv]
// Per-tick mode logic and knob state registers of the haptic knob mode controller.
module hkmc_core
   import hkmc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int W1 = FIXED_WIDTH + 1;
   localparam int W2 = FIXED_WIDTH + 2;

   logic signed [FIXED_WIDTH-1:0] prev_angle_ff,    prev_angle_in;
   logic signed [FIXED_WIDTH-1:0] prev_velocity_ff, prev_velocity_in;
   logic signed [FIXED_WIDTH-1:0] target_ff,        target_in;
   logic [DRIVE_WIDTH-1:0]        drive_mode_ff,    drive_mode_in;
   logic [FIXED_WIDTH-1:0]        detent_count_ff,  detent_count_in;

   logic [W1-1:0]                 vel_mag;
   logic signed [W2-1:0]          vel_diff;
   logic [W2-1:0]                 vel_diff_mag;
   logic                          vel_over_band;
   logic                          vel_jumped;
   logic signed [W1-1:0]          angle_diff;
   logic signed [W2-1:0]          angle_diff2;
   logic signed [W2-1:0]          step_wide;
   logic                          step_up;
   logic                          step_down;
   logic signed [FIXED_WIDTH-1:0] target_up;
   logic signed [FIXED_WIDTH-1:0] target_down;
   logic                          limits_on;

   // Inertia: velocity magnitude against deadband, velocity change against jump
   assign vel_mag       = item.velocity[FIXED_WIDTH-1]
                        ? W1'(0) - {item.velocity[FIXED_WIDTH-1], item.velocity}
                        : {1'b0, item.velocity};
   assign vel_over_band = vel_mag > {{(W1-BAND_WIDTH){1'b0}}, cfg.inertia_deadband};
   assign vel_diff      = $signed({{2{item.velocity[FIXED_WIDTH-1]}}, item.velocity})
                        - $signed({{2{prev_velocity_ff[FIXED_WIDTH-1]}}, prev_velocity_ff});
   assign vel_diff_mag  = vel_diff[W2-1] ? W2'(0) - $unsigned(vel_diff) : $unsigned(vel_diff);
   assign vel_jumped    = vel_diff_mag > {{(W2-BAND_WIDTH){1'b0}}, cfg.inertia_jump};

   // Encoder: twice the angle travel against one step, i.e. half a detent
   assign angle_diff  = $signed({item.angle[FIXED_WIDTH-1], item.angle})
                      - $signed({prev_angle_ff[FIXED_WIDTH-1], prev_angle_ff});
   assign angle_diff2 = $signed({angle_diff, 1'b0});
   assign step_wide   = $signed({{(W2-STEP_WIDTH){1'b0}}, cfg.detent_step});
   assign step_up     = angle_diff2 > step_wide;
   assign step_down   = angle_diff2 < -step_wide;
   assign target_up   = target_ff
                      + $signed({{(FIXED_WIDTH-STEP_WIDTH){1'b0}}, cfg.detent_step});
   assign target_down = target_ff
                      - $signed({{(FIXED_WIDTH-STEP_WIDTH){1'b0}}, cfg.detent_step});

   // Bounded: limits count only when both are set
   assign limits_on = (cfg.limit_high != '0) && (cfg.limit_low != '0);

   // Next state
   always_comb begin
      prev_angle_in    = prev_angle_ff;
      prev_velocity_in = prev_velocity_ff;
      target_in        = target_ff;
      drive_mode_in    = drive_mode_ff;
      detent_count_in  = detent_count_ff;
      if (step_en) begin
         if (item.restart) begin
            // mode entry values
            prev_angle_in    = item.angle;
            prev_velocity_in = item.velocity;
            case (cfg.knob_mode)
               MODE_FLYWHEEL, MODE_BOUNDED: begin
                  drive_mode_in = DRIVE_VELOCITY;
                  target_in     = '0;
               end
               MODE_DETENT: begin
                  drive_mode_in = DRIVE_ANGLE;
                  target_in     = '0;
                  prev_angle_in = '0;
               end
               MODE_RETURN, MODE_HOST: begin
                  drive_mode_in = DRIVE_ANGLE;
                  target_in     = '0;
               end
               MODE_ROTATE: begin
                  drive_mode_in = DRIVE_VELOCITY;
                  target_in     = SPIN_TARGET;
               end
               default: ;
            endcase
         end else begin
            // normal tick
            case (cfg.knob_mode)
               MODE_FLYWHEEL: begin
                  if (vel_over_band) begin
                     if (vel_jumped) target_in = item.velocity;
                  end else begin
                     target_in = '0;
                  end
                  prev_velocity_in = item.velocity;
               end
               MODE_DETENT: begin
                  if (step_up) begin
                     target_in       = target_up;
                     prev_angle_in   = target_up;
                     detent_count_in = detent_count_ff + FIXED_WIDTH'(1);
                  end else if (step_down) begin
                     target_in       = target_down;
                     prev_angle_in   = target_down;
                     detent_count_in = detent_count_ff - FIXED_WIDTH'(1);
                  end
               end
               MODE_BOUNDED: begin
                  if (limits_on) begin
                     if (item.angle > cfg.limit_high) begin
                        drive_mode_in = DRIVE_ANGLE;
                        target_in     = cfg.limit_high;
                     end else if (item.angle < cfg.limit_low) begin
                        drive_mode_in = DRIVE_ANGLE;
                        target_in     = cfg.limit_low;
                     end else begin
                        drive_mode_in = DRIVE_VELOCITY;
                        target_in     = '0;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_angle_ff    <= '0;
         prev_velocity_ff <= '0;
         target_ff        <= '0;
         drive_mode_ff    <= DRIVE_TORQUE;
         detent_count_ff  <= '0;
      end else begin
         prev_angle_ff    <= prev_angle_in;
         prev_velocity_ff <= prev_velocity_in;
         target_ff        <= target_in;
         drive_mode_ff    <= drive_mode_in;
         detent_count_ff  <= detent_count_in;
      end
   end

   // Command built from the updated state
   always_comb begin
      result.motor_enable = mode_enables(cfg.knob_mode);
      result.drive_mode   = drive_mode_in;
      result.motor_target = target_in;
      result.torque_cap   = cap_for(cfg.knob_mode);
      result.detent_count = $signed(detent_count_in);
   end

endmodule

[hdl/haptic_knob_mode_controller_top.sv]
// Top level of the haptic knob mode controller: request register, mode core, response register.
//
// Takes one request per clock while the response side does not stall, and returns one motor
// command per request, in order. A request waits in the input register; at the edge on which it
// advances, the mode logic updates the knob state and loads the response register. The single
// state update per cycle in the core sets the rate at one request per clock when nothing stalls.
// The response register keeps a finished command while the input register already takes the
// next request. csr_ready is always high; the user must write registers only while no request
// is in flight, and the block itself does not enforce it.
module haptic_knob_mode_controller_top
   import hkmc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   // configuration port
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type cfg;
   rsp_type core_result;

   logic    in_valid_ff,  in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    advance;
   logic    req_take;

   // Pipeline handshake
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) in_data_ff  <= req_data;
      if (advance)  out_data_ff <= core_result;
   end

   hkmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hkmc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[hdl/hkmc_checker.sv]
// Port-level assertions for the haptic knob mode controller, bound to the top level.
module hkmc_checker
   import hkmc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Torque cap is zero exactly when the motor is off
   a_cap_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.motor_enable == (rsp_data.torque_cap != '0)))
      else $error("torque cap disagrees with motor enable");

   // Drive mode is a defined code
   a_drive_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.drive_mode == DRIVE_TORQUE ||
                     rsp_data.drive_mode == DRIVE_VELOCITY ||
                     rsp_data.drive_mode == DRIVE_ANGLE))
      else $error("undefined drive mode");

   // Accepted request reaches the output when the response side is free
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("response missing after request");

endmodule

bind haptic_knob_mode_controller_top hkmc_checker u_hkmc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
